>>> sv/bap_pkg.sv
`default_nettype none

package bap_pkg;

    // Depth of the averaging ring.
    localparam int WINDOW = 10;

    localparam int ADC_W     = 12;
    localparam int MV_W      = 15;
    localparam int PCT_W     = 7;
    localparam int SUM_W     = 16;
    localparam int IDX_W     = 4;
    // One bit more than the index; it holds the fill count of the ring, up to ten.
    localparam int CNT_W     = IDX_W + 1;
    localparam int CFG_IDX_W = 2;

    // Widest dividend the shared divider sees: a code times a millivolt scale.
    localparam int DIV_NUM_W = ADC_W + MV_W;
    localparam int DIV_CNT_W = 5;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    localparam logic [MV_W-1:0]  ADC_MAX_CODE = 15'd4095;
    localparam logic [PCT_W-1:0] PCT_FULL     = 7'd100;
    localparam logic [PCT_W-1:0] PCT_EMPTY    = 7'd0;

    localparam logic [MV_W-1:0] FULL_SCALE_RST = 15'd6600;
    localparam logic [MV_W-1:0] FULL_MV_RST    = 15'd4200;
    localparam logic [MV_W-1:0] EMPTY_MV_RST   = 15'd3300;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FULL_SCALE = 2'd0,
        REG_FULL_MV    = 2'd1,
        REG_EMPTY_MV   = 2'd2
    } cfg_reg_t;

    // One request to the bit-serial divider. The partial remainder must start
    // below the divisor; the dividend bits are consumed from the top down.
    typedef struct packed {
        logic [MV_W-1:0]      rem;
        logic [DIV_NUM_W-1:0] num;
        logic [MV_W-1:0]      den;
        logic [DIV_CNT_W-1:0] steps;
    } div_req_t;

endpackage

`default_nettype wire

>>> sv/battery_average_and_percent.sv
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   adc_sample
// m_axis    out        m_axis_tvalid/m_axis_tready   average_code, voltage_mv, charge_percent
// cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data
//
// A result is offered once its sample has passed the average division, the shift-add
// multiplication, the millivolt division and, unless the charge is clamped, the percent
// division; only then is a new sample taken. The shared bit-serial divider gives 12, 15
// and 7 quotient bits, one per cycle. After reset the ring is empty, the registers hold
// their defaults and no beat is taken while reset is held. While the output register is
// stalled the next result waits and no further sample is taken.
`default_nettype none

module battery_average_and_percent
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [11:0] adc_sample, [15:12] zero
    input  wire logic [bap_pkg::S_TDATA_W-1:0]   s_axis_tdata,

    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [11:0] average_code, [26:12] voltage_mv, [33:27] charge_percent, [39:34] zero
    output logic [bap_pkg::M_TDATA_W-1:0]        m_axis_tdata,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bap_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bap_pkg::MV_W-1:0]        cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_AVG  = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_MV   = 7'b0001000,
        S_PCT  = 7'b0010000,
        S_PDIV = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    state_t                                state_reg, state_next;
    logic [bap_pkg::IDX_W-1:0]             idx_reg, idx_next;
    logic                                  full_reg, full_next;
    logic [bap_pkg::SUM_W-1:0]             sum_reg, sum_next;
    logic [bap_pkg::MV_W-1:0]              fs_reg, fs_next;
    logic [bap_pkg::MV_W-1:0]              full_mv_reg, full_mv_next;
    logic [bap_pkg::MV_W-1:0]              empty_mv_reg, empty_mv_next;
    logic                                  start_reg, start_next;
    logic                                  out_valid_reg, out_valid_next;
    logic [bap_pkg::IDX_W-1:0]             mul_cnt_reg, mul_cnt_next;

    bap_pkg::div_req_t                     req_reg, req_next;
    logic [bap_pkg::ADC_W-1:0]             avg_reg, avg_next;
    logic [bap_pkg::MV_W-1:0]              mv_reg, mv_next;
    logic [bap_pkg::PCT_W-1:0]             pct_reg, pct_next;
    logic [bap_pkg::DIV_NUM_W-1:0]         acc_reg, acc_next;
    logic [bap_pkg::M_TDATA_W-1:0]         out_data_reg, out_data_next;

    logic [bap_pkg::ADC_W-1:0]             ring_reg [bap_pkg::WINDOW];

    logic                                  in_fire;
    logic                                  out_free;
    logic [bap_pkg::ADC_W-1:0]             code;
    logic [bap_pkg::ADC_W-1:0]             old_code;
    logic                                  wrap;
    logic [bap_pkg::IDX_W-1:0]             idx_inc;
    logic                                  full_upd;
    logic [bap_pkg::SUM_W-1:0]             sum_upd;
    logic [bap_pkg::CNT_W-1:0]             count;
    logic [bap_pkg::DIV_NUM_W-1:0]         acc_step;
    logic [bap_pkg::MV_W-1:0]              diff;
    logic [bap_pkg::MV_W-1:0]              span;
    logic [bap_pkg::MV_W+bap_pkg::PCT_W-1:0] scaled;

    logic                                  div_done;
    logic [bap_pkg::MV_W-1:0]              div_quot;

    bap_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .req   (req_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // No beat is taken while reset is held.
    assign s_axis_tready = rst_n & (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~out_valid_reg | m_axis_tready;
    assign cfg_ready     = rst_n;

    assign code     = s_axis_tdata[bap_pkg::ADC_W-1:0];
    assign old_code = ring_reg[idx_reg];
    assign wrap     = (idx_reg == bap_pkg::IDX_W'(bap_pkg::WINDOW - 1));
    assign idx_inc  = wrap ? '0 : idx_reg + bap_pkg::IDX_W'(1);
    assign full_upd = full_reg | wrap;
    assign sum_upd  = sum_reg
                    - (full_reg ? {4'b0000, old_code} : bap_pkg::SUM_W'(0))
                    + {4'b0000, code};
    assign count    = full_upd ? bap_pkg::CNT_W'(bap_pkg::WINDOW) : {1'b0, idx_inc};

    // MSB-first shift-add; the average code is rotated so it is whole again
    // after the last step.
    assign acc_step = {acc_reg[bap_pkg::DIV_NUM_W-2:0], 1'b0}
                    + (avg_reg[bap_pkg::ADC_W-1] ? {12'd0, fs_reg}
                                                 : bap_pkg::DIV_NUM_W'(0));

    assign diff   = mv_reg - empty_mv_reg;
    assign span   = full_mv_reg - empty_mv_reg;
    // Times one hundred as 64 + 32 + 4.
    assign scaled = ({7'd0, diff} << 6) + ({7'd0, diff} << 5) + ({7'd0, diff} << 2);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        full_next      = full_reg;
        sum_next       = sum_reg;
        fs_next        = fs_reg;
        full_mv_next   = full_mv_reg;
        empty_mv_next  = empty_mv_reg;
        start_next     = 1'b0;
        mul_cnt_next   = mul_cnt_reg;
        req_next       = req_reg;
        avg_next       = avg_reg;
        mv_next        = mv_reg;
        pct_next       = pct_reg;
        acc_next       = acc_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                bap_pkg::REG_FULL_SCALE: fs_next       = cfg_data;
                bap_pkg::REG_FULL_MV:    full_mv_next  = cfg_data;
                bap_pkg::REG_EMPTY_MV:   empty_mv_next = cfg_data;
                default:                 ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    idx_next       = idx_inc;
                    full_next      = full_upd;
                    sum_next       = sum_upd;
                    // The mean never exceeds a full-scale code, so twelve
                    // quotient bits suffice.
                    req_next.rem   = {11'd0, sum_upd[bap_pkg::SUM_W-1:bap_pkg::ADC_W]};
                    req_next.num   = {sum_upd[bap_pkg::ADC_W-1:0], 15'd0};
                    req_next.den   = bap_pkg::MV_W'(count);
                    req_next.steps = bap_pkg::DIV_CNT_W'(bap_pkg::ADC_W);
                    start_next     = 1'b1;
                    state_next     = S_AVG;
                end
            end
            S_AVG:
            begin
                if (div_done)
                begin
                    avg_next     = div_quot[bap_pkg::ADC_W-1:0];
                    acc_next     = '0;
                    mul_cnt_next = '0;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                acc_next     = acc_step;
                avg_next     = {avg_reg[bap_pkg::ADC_W-2:0], avg_reg[bap_pkg::ADC_W-1]};
                mul_cnt_next = mul_cnt_reg + bap_pkg::IDX_W'(1);
                if (mul_cnt_reg == bap_pkg::IDX_W'(bap_pkg::ADC_W - 1))
                begin
                    req_next.rem   = {3'd0, acc_step[bap_pkg::DIV_NUM_W-1:bap_pkg::MV_W]};
                    req_next.num   = {acc_step[bap_pkg::MV_W-1:0], 12'd0};
                    req_next.den   = bap_pkg::ADC_MAX_CODE;
                    req_next.steps = bap_pkg::DIV_CNT_W'(bap_pkg::MV_W);
                    start_next     = 1'b1;
                    state_next     = S_MV;
                end
            end
            S_MV:
            begin
                if (div_done)
                begin
                    mv_next    = div_quot;
                    state_next = S_PCT;
                end
            end
            S_PCT:
            begin
                // The full test comes first, so an inverted span never divides.
                if (mv_reg >= full_mv_reg)
                begin
                    pct_next   = bap_pkg::PCT_FULL;
                    state_next = S_FIN;
                end
                else if (mv_reg <= empty_mv_reg)
                begin
                    pct_next   = bap_pkg::PCT_EMPTY;
                    state_next = S_FIN;
                end
                else
                begin
                    req_next.rem   = scaled[bap_pkg::MV_W+bap_pkg::PCT_W-1:bap_pkg::PCT_W];
                    req_next.num   = {scaled[bap_pkg::PCT_W-1:0], 20'd0};
                    req_next.den   = span;
                    req_next.steps = bap_pkg::DIV_CNT_W'(bap_pkg::PCT_W);
                    start_next     = 1'b1;
                    state_next     = S_PDIV;
                end
            end
            S_PDIV:
            begin
                if (div_done)
                begin
                    pct_next   = div_quot[bap_pkg::PCT_W-1:0];
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_data_next  = {6'd0, pct_reg, mv_reg, avg_reg};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            full_reg      <= 1'b0;
            sum_reg       <= '0;
            fs_reg        <= bap_pkg::FULL_SCALE_RST;
            full_mv_reg   <= bap_pkg::FULL_MV_RST;
            empty_mv_reg  <= bap_pkg::EMPTY_MV_RST;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            mul_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            full_reg      <= full_next;
            sum_reg       <= sum_next;
            fs_reg        <= fs_next;
            full_mv_reg   <= full_mv_next;
            empty_mv_reg  <= empty_mv_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            mul_cnt_reg   <= mul_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        avg_reg      <= avg_next;
        mv_reg       <= mv_next;
        pct_reg      <= pct_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
        if (in_fire)
        begin
            ring_reg[idx_reg] <= code;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> sv/bap_div.sv
`default_nettype none

module bap_div
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire bap_pkg::div_req_t           req,
    output logic                             done,
    output logic [bap_pkg::MV_W-1:0]         quot
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [bap_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [bap_pkg::MV_W-1:0]         rem_reg;
    logic [bap_pkg::MV_W-1:0]         den_reg;
    logic [bap_pkg::MV_W-1:0]         quot_reg;
    logic [bap_pkg::DIV_NUM_W-1:0]    num_reg;

    logic [bap_pkg::MV_W:0]           shifted;
    logic [bap_pkg::MV_W+1:0]         trial;
    logic                             fits;

    // One restoring step per cycle: bring down the next dividend bit and try
    // to take the divisor away.
    assign shifted = {rem_reg, num_reg[bap_pkg::DIV_NUM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign fits    = ~trial[bap_pkg::MV_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == bap_pkg::DIV_CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - bap_pkg::DIV_CNT_W'(1);
                if (cnt_reg == bap_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= req.rem;
            num_reg  <= req.num;
            den_reg  <= req.den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? trial[bap_pkg::MV_W-1:0] : shifted[bap_pkg::MV_W-1:0];
            num_reg  <= {num_reg[bap_pkg::DIV_NUM_W-2:0], 1'b0};
            quot_reg <= {quot_reg[bap_pkg::MV_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

>>> sv/bap_checker.sv
`default_nettype none

module bap_checker
(
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [bap_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    // A result beat, once offered, stays until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat withdrawn before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // The charge estimate is clamped.
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[33:27] <= bap_pkg::PCT_FULL))
        else $error("charge percentage above one hundred");

    // Samples are worked one at a time: no sample is taken straight after another.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("sample beat taken while the previous one is in work");

endmodule

bind battery_average_and_percent bap_checker u_bap_checker (.*);

`default_nettype wire
